[design/rsbk_pkg.sv]
// Shared types and constants for the record sort-by-key unit.
package rsbk_pkg;

  // Width of a record's sort key
  localparam int KEY_W = 32;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE       = 8'b0000_0001,
    ST_SORT_START = 8'b0000_0010,
    ST_SORT_HEAD  = 8'b0000_0100,
    ST_SORT_STEP  = 8'b0000_1000,
    ST_SORT_TAIL  = 8'b0001_0000,
    ST_EMIT_RD    = 8'b0010_0000,
    ST_EMIT_LD    = 8'b0100_0000,
    ST_EMIT_WAIT  = 8'b1000_0000
  } rsbk_state_t;

endpackage

[design/record_sort_by_key_unit.sv]
// Record sort-by-key unit: batch store, stable bubble sort and ordered emit.
//
// Usage:
//   Records enter on the in_ channel (valid/stall), one transaction per record,
//   each with a signed key and a payload handle. in_last_in closes the batch.
//   While loading, a record is taken every cycle. Records beyond CAPACITY are
//   dropped and the batch is flagged on out_overflow.
//   After the closing record the unit stalls its input, sorts the batch in
//   ascending key order (equal keys keep arrival order) and emits one out_
//   transaction per stored record; out_last_out marks the final one.
//   Phases for a batch of n stored records:
//     load:  each record is written to the record RAM as it is taken.
//     sort:  n-1 passes, n(n-1)/2 compare steps in all, each needing one read
//            of the record RAM; each pass also has a start, head and tail state.
//     emit:  a read state to start, then per record a load and a wait state;
//            the next record is read only once the receiver takes the current one.
//   When the receiver holds out_stall, the output register keeps its
//   transaction and the sequencer waits. Reset (rst_n low, synchronous)
//   empties the batch and clears the overflow flag; the RAM is not cleared.
module record_sort_by_key_unit #(
  parameter int CAPACITY     = 32,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rsbk_pkg::KEY_W-1:0]  in_key,
  input  logic [PAYLOAD_BITS-1:0]     in_payload,
  input  logic                        in_last_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rsbk_pkg::KEY_W-1:0]  out_sorted_key,
  output logic [PAYLOAD_BITS-1:0]     out_sorted_payload,
  output logic                        out_last_out,
  output logic                        out_overflow
);

  import rsbk_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int W     = KEY_W + PAYLOAD_BITS;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO     = CNT_W'(2);

  rsbk_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [W-1:0]     carry_r;
  logic             carry_ld;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ld;
  logic [KEY_W-1:0] out_key_r;
  logic [PAYLOAD_BITS-1:0] out_payload_r;
  logic             out_last_r;
  logic             out_ovf_r;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [W-1:0]     ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [W-1:0]     ram_rdata;

  logic             in_acc;
  logic             key_gt;
  logic [CNT_W-1:0] batch_len;
  logic [CNT_W-1:0] pos_p1;
  logic [CNT_W-1:0] pos_p2;
  logic [CNT_W-1:0] idx_p1;
  logic [CNT_W-1:0] len_m1;

  // Record store
  rsbk_ram #(
    .WIDTH (W),
    .DEPTH (CAPACITY)
  ) u_rsbk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign batch_len = (count_r < CAP_CNT) ? count_r + ONE : count_r;
  assign pos_p1    = pos_r + ONE;
  assign pos_p2    = pos_r + TWO;
  assign idx_p1    = idx_r + ONE;
  assign len_m1    = len_r - ONE;

  // Signed key compare: carried record against the record just read
  assign key_gt = $signed(carry_r[W-1 -: KEY_W]) > $signed(ram_rdata[W-1 -: KEY_W]);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    carry_ld      = 1'b0;
    out_valid_nxt = out_valid_r;
    out_ld        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = carry_r;
    ram_raddr     = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // store the record or flag the drop
          if (count_r < CAP_CNT) begin
            ram_we    = 1'b1;
            ram_waddr = count_r[AW-1:0];
            ram_wdata = {in_key, in_payload};
            count_nxt = count_r + ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_in) begin
            len_nxt = batch_len;
            idx_nxt = '0;
            state_nxt = (batch_len >= TWO) ? ST_SORT_START : ST_EMIT_RD;
          end
        end
      end
      ST_SORT_START: begin
        // fetch the first record of the pass
        ram_raddr = '0;
        state_nxt = ST_SORT_HEAD;
      end
      ST_SORT_HEAD: begin
        // carry the first record, fetch the second
        carry_ld  = 1'b1;
        ram_raddr = ONE[AW-1:0];
        pos_nxt   = '0;
        state_nxt = ST_SORT_STEP;
      end
      ST_SORT_STEP: begin
        // keep the larger key moving, drop the smaller one into place
        ram_we    = 1'b1;
        ram_waddr = pos_r[AW-1:0];
        if (key_gt) begin
          ram_wdata = ram_rdata;
        end else begin
          ram_wdata = carry_r;
          carry_ld  = 1'b1;
        end
        ram_raddr = pos_p2[AW-1:0];
        pos_nxt   = pos_p1;
        if (pos_p2 == len_r) begin
          state_nxt = ST_SORT_TAIL;
        end
      end
      ST_SORT_TAIL: begin
        // settle the largest record at the end of the pass
        ram_we    = 1'b1;
        ram_waddr = len_m1[AW-1:0];
        ram_wdata = carry_r;
        len_nxt   = len_m1;
        idx_nxt   = '0;
        state_nxt = (len_m1 >= TWO) ? ST_SORT_START : ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        ram_raddr = idx_r[AW-1:0];
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_ld        = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        // advance once the receiver takes the transaction
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_p1;
            ram_raddr = idx_p1[AW-1:0];
            state_nxt = ST_EMIT_LD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      len_r       <= '0;
      pos_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Data registers: carried record and output transaction
  always_ff @(posedge clk) begin
    if (carry_ld) begin
      carry_r <= ram_rdata;
    end
    if (out_ld) begin
      out_key_r     <= ram_rdata[W-1 -: KEY_W];
      out_payload_r <= ram_rdata[PAYLOAD_BITS-1:0];
      out_last_r    <= (idx_p1 == count_r);
      out_ovf_r     <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sorted_key     = out_key_r;
  assign out_sorted_payload = out_payload_r;
  assign out_last_out       = out_last_r;
  assign out_overflow       = out_ovf_r;

endmodule

[design/rsbk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rsbk_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/rsbk_checker.sv]
// Port-level checker for the record sort-by-key unit, bound to the top level.
module rsbk_checker #(
  parameter int PAYLOAD_BITS = 16
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_last_in,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [rsbk_pkg::KEY_W-1:0]  out_sorted_key,
  input logic [PAYLOAD_BITS-1:0]     out_sorted_payload,
  input logic                        out_last_out,
  input logic                        out_overflow
);

  import rsbk_pkg::*;

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sorted_key) &&
      $stable(out_sorted_payload) && $stable(out_last_out) && $stable(out_overflow))
    else $error("stalled output transaction changed");

  // Input is closed while results are pending
  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while emitting");

  // Closing record stops the input for sorting
  a_close_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_in |=> in_stall)
    else $error("input open after batch close");

  // Loading continues at one record per cycle
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last_in |=> !in_stall && !out_valid)
    else $error("input stalled during load");

endmodule

bind record_sort_by_key_unit rsbk_checker #(
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_rsbk_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_last_in         (in_last_in),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_sorted_key     (out_sorted_key),
  .out_sorted_payload (out_sorted_payload),
  .out_last_out       (out_last_out),
  .out_overflow       (out_overflow)
);

[verif/record_sort_by_key_unit_test.sv]
`timescale 1ns / 1ps
// Testbench for the record sort-by-key unit: batches of records checked against a stable sort.
module record_sort_by_key_unit_test;
  import rsbk_pkg::*;

  localparam int CAPACITY     = 32;
  localparam int PAYLOAD_BITS = 16;
  localparam int RANDOM_ITEMS = 300;

  // One record as it leaves the unit
  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    last_out;
    logic                    overflow;
  } sorted_rec_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [KEY_W-1:0]        in_key = '0;
  logic [PAYLOAD_BITS-1:0] in_payload = '0;
  logic                    in_last_in = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [KEY_W-1:0]        out_sorted_key;
  logic [PAYLOAD_BITS-1:0] out_sorted_payload;
  logic                    out_last_out;
  logic                    out_overflow;

  // Records of the open batch, in arrival order
  sorted_rec_t open_batch_q[$];
  logic        batch_dropped = 1'b0;
  // Sorted records still owed by the unit
  sorted_rec_t sorted_q[$];

  int error_count = 0;
  bit tx_gaps_on  = 1'b0;
  bit rx_gaps_on  = 1'b0;
  int rx_hold_req = 0;
  int stall_left  = 0;

  record_sort_by_key_unit #(
    .CAPACITY    (CAPACITY),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_key            (in_key),
    .in_payload        (in_payload),
    .in_last_in        (in_last_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sorted_key    (out_sorted_key),
    .out_sorted_payload(out_sorted_payload),
    .out_last_out      (out_last_out),
    .out_overflow      (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap(bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(99);
    if (r < 80) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mix of full-range, tie-heavy and extreme keys
  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(6) - 32'd3;
      7: begin
        case ($urandom_range(3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return '1;
          default: return '0;
        endcase
      end
      default:    return {1'($urandom_range(1)), 31'($urandom)};
    endcase
  endfunction

  // Store the record, and on the batch close sort and queue the expected records
  function automatic void accept_record(logic [KEY_W-1:0] key,
                                        logic [PAYLOAD_BITS-1:0] payload, logic last);
    sorted_rec_t rec;
    int i;
    int j;
    rec = '{key: key, payload: payload, last_out: 1'b0, overflow: 1'b0};
    if (open_batch_q.size() < CAPACITY) open_batch_q.push_back(rec);
    else batch_dropped = 1'b1;
    if (!last) return;
    // Insertion sort; move only past strictly greater keys to keep ties in order
    for (i = 1; i < open_batch_q.size(); i++) begin
      rec = open_batch_q[i];
      j = i;
      while (j > 0 && $signed(open_batch_q[j-1].key) > $signed(rec.key)) begin
        open_batch_q[j] = open_batch_q[j-1];
        j--;
      end
      open_batch_q[j] = rec;
    end
    for (i = 0; i < open_batch_q.size(); i++) begin
      rec = open_batch_q[i];
      rec.last_out = (i == open_batch_q.size() - 1);
      rec.overflow = batch_dropped;
      sorted_q.push_back(rec);
    end
    open_batch_q.delete();
    batch_dropped = 1'b0;
  endfunction

  // Offer one record and hold it until the unit takes the transaction
  task automatic send_record(input logic [KEY_W-1:0] key,
                             input logic [PAYLOAD_BITS-1:0] payload, input logic last);
    int gap;
    gap = pick_gap(tx_gaps_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_key     <= key;
    in_payload <= payload;
    in_last_in <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accept_record(key, payload, last);
  endtask

  task automatic send_random_batch(input int len);
    int k;
    for (k = 0; k < len; k++) begin
      send_record(rand_key(), PAYLOAD_BITS'($urandom), k == len - 1);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
  endtask

  // Check each transaction on the result side and pick the next stall
  always @(posedge clk) begin
    sorted_rec_t got;
    sorted_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{key: out_sorted_key, payload: out_sorted_payload,
              last_out: out_last_out, overflow: out_overflow};
      if (sorted_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected sorted record: key %0d payload 0x%h last %b ovf %b",
                 $time, $signed(got.key), got.payload, got.last_out, got.overflow);
      end else begin
        want = sorted_q.pop_front();
        if (got !== want) begin
          error_count++;
          $display("%0t: mismatch: expected key %0d payload 0x%h last %b ovf %b, got key %0d payload 0x%h last %b ovf %b",
                   $time, $signed(want.key), want.payload, want.last_out, want.overflow,
                   $signed(got.key), got.payload, got.last_out, got.overflow);
        end
      end
    end
    if (rx_hold_req != 0) begin
      stall_left  = rx_hold_req;
      rx_hold_req = 0;
    end else if (stall_left == 0) begin
      stall_left = pick_gap(rx_gaps_on);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One record that closes its own batch
  task automatic test_single_record();
    send_record(32'h1234_5678, 16'hA5A5, 1'b1);
  endtask

  // Key and payload extremes in one batch
  task automatic test_key_extremes();
    send_record(32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    send_record(32'h8000_0000, 16'h0000, 1'b0);
    send_record(32'hFFFF_FFFF, 16'h5555, 1'b0);
    send_record(32'h0000_0000, 16'hAAAA, 1'b0);
    send_record(32'h0000_0001, 16'h0001, 1'b0);
    send_record(32'h8000_0001, 16'h8000, 1'b1);
  endtask

  // Equal keys must keep arrival order
  task automatic test_equal_keys_stable();
    send_record(32'd7, 16'd1, 1'b0);
    send_record(-32'sd3, 16'd2, 1'b0);
    send_record(32'd7, 16'd3, 1'b0);
    send_record(-32'sd3, 16'd4, 1'b0);
    send_record(32'd7, 16'd5, 1'b1);
  endtask

  // Already sorted batch, then a fully reversed one
  task automatic test_sorted_and_reversed();
    send_record(-32'sd10, 16'h0010, 1'b0);
    send_record(32'd0, 16'h0020, 1'b0);
    send_record(32'd10, 16'h0030, 1'b1);
    send_record(32'd10, 16'h0040, 1'b0);
    send_record(32'd0, 16'h0050, 1'b0);
    send_record(-32'sd10, 16'h0060, 1'b1);
  endtask

  // Exactly CAPACITY records: no overflow
  task automatic test_full_batch();
    send_random_batch(CAPACITY);
  endtask

  // Closing record dropped, then a longer overrun, then a clean batch
  task automatic test_overflow();
    send_random_batch(CAPACITY + 1);
    send_random_batch(CAPACITY + 8);
    send_random_batch(3);
  endtask

  // Hold the result side long enough that the unit stalls its input
  task automatic test_backpressure();
    rx_hold_req = 400;
    send_random_batch(6);
    send_random_batch(10);
    wait_for_results();
  endtask

  // Random batches, mostly small, with gaps switched per batch
  task automatic test_random_batches();
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 90) len = $urandom_range(9, 24);
      else if (r < 97) len = $urandom_range(25, CAPACITY);
      else len = $urandom_range(CAPACITY + 1, CAPACITY + 8);
      tx_gaps_on = ($urandom_range(9) < 8);
      rx_gaps_on = ($urandom_range(9) < 8);
      send_random_batch(len);
      sent += len;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_record();
    test_key_extremes();
    test_equal_keys_stable();
    test_sorted_and_reversed();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    test_full_batch();
    test_overflow();
    wait_for_results();
    test_backpressure();
    test_random_batches();
    wait_for_results();
    repeat (50) @(posedge clk);
    if (error_count == 0 && sorted_q.size() == 0) begin
      $display("record_sort_by_key_unit_test: PASS");
    end else begin
      $display("record_sort_by_key_unit_test: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("record_sort_by_key_unit_test: FAIL");
    $finish;
  end

endmodule
